// ===== hdl/cdd_pkg.sv =====
// Shared constants, stage control types and calendar tables for the date difference block.
`default_nettype none

package cdd_pkg;

  // Year offset that keeps every shifted year positive.
  localparam int unsigned YEAR_OFFSET     = 400;
  // Reciprocal of 100 scaled by 2^19; exact for quotients of operands below 2^15.
  localparam int unsigned RECIP_100       = 5243;
  localparam int unsigned RECIP_100_SHIFT = 19;
  // Reciprocal of 7 scaled by 2^27; exact for magnitudes below 2^24.
  localparam int unsigned RECIP_7         = 19173962;
  localparam int unsigned RECIP_7_SHIFT   = 27;
  localparam int unsigned CENTURY         = 100;
  localparam int unsigned DAYS_PER_YEAR   = 365;
  localparam int unsigned MONTHS_PER_YEAR = 12;
  localparam int unsigned HOURS_PER_DAY   = 24;
  localparam int unsigned MINS_PER_HOUR   = 60;
  localparam int unsigned SECS_PER_MIN    = 60;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_APR = 4'd4;
  localparam logic [3:0] MONTH_JUN = 4'd6;
  localparam logic [3:0] MONTH_SEP = 4'd9;
  localparam logic [3:0] MONTH_NOV = 4'd11;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  // Clock enables of the two stages inside a date unit.
  typedef struct packed {
    logic s1;
    logic s2;
  } stage_en_t;

  function automatic logic [4:0] month_length(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    unique case (month)
      MONTH_FEB: len = leap ? 5'd29 : 5'd28;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // Days before the first of the month, counting from March as the first month.
  function automatic logic [8:0] month_offset(input logic [3:0] month);
    logic [8:0] off;
    unique case (month)
      4'd0:  off = 9'd275;
      4'd1:  off = 9'd306;
      4'd2:  off = 9'd337;
      4'd3:  off = 9'd0;
      4'd4:  off = 9'd31;
      4'd5:  off = 9'd61;
      4'd6:  off = 9'd92;
      4'd7:  off = 9'd122;
      4'd8:  off = 9'd153;
      4'd9:  off = 9'd184;
      4'd10: off = 9'd214;
      4'd11: off = 9'd245;
      4'd12: off = 9'd275;
      4'd13: off = 9'd306;
      4'd14: off = 9'd337;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/calendar_datetime_difference.sv =====
// An accepted item shows its result from the sixth register, the output register.
// One item per cycle while the output is not stalled; every stage is a plain register with a valid bit.
// A stalled output holds only the full stages behind it; empty stages keep filling.
// The widest steps are the reciprocal multiplications by 1/100 and 1/7.
// Reset clears the valid bits at once and asynchronously; payload registers are not reset.
`default_nettype none

module calendar_datetime_difference (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire [13:0]         a_year_i,
  input  wire [3:0]          a_month_i,
  input  wire [4:0]          a_day_i,
  input  wire [4:0]          a_hour_i,
  input  wire [5:0]          a_minute_i,
  input  wire [5:0]          a_second_i,
  input  wire [13:0]         b_year_i,
  input  wire [3:0]          b_month_i,
  input  wire [4:0]          b_day_i,
  input  wire [4:0]          b_hour_i,
  input  wire [5:0]          b_minute_i,
  input  wire [5:0]          b_second_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic               both_valid_o,
  output logic signed [14:0] year_diff_o,
  output logic signed [17:0] month_diff_o,
  output logic signed [22:0] day_diff_o,
  output logic signed [19:0] week_diff_o,
  output logic signed [27:0] hour_diff_o,
  output logic signed [33:0] minute_diff_o,
  output logic signed [39:0] second_diff_o
);

  // A stage advances when it is empty or the stage after it advances.
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic e1, e2, e3, e4, e5, e6;

  always_comb begin
    e6 = !v6_q || !out_stall_i;
    e5 = !v5_q || e6;
    e4 = !v4_q || e5;
    e3 = !v3_q || e4;
    e2 = !v2_q || e3;
    e1 = !v1_q || e2;
  end

  assign in_stall_o  = !e1;
  assign out_valid_o = v6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (e1) v1_q <= in_valid_i;
      if (e2) v2_q <= v1_q;
      if (e3) v3_q <= v2_q;
      if (e4) v4_q <= v3_q;
      if (e5) v5_q <= v4_q;
      if (e6) v6_q <= v5_q;
    end
  end

  cdd_pkg::stage_en_t unit_en;
  logic [23:0] day_num_a, day_num_b;
  logic        ok_a, ok_b;

  assign unit_en.s1 = e1;
  assign unit_en.s2 = e2;

  cdd_date_unit u_date_a (
    .clk_i     (clk_i),
    .en_i      (unit_en),
    .year_i    (a_year_i),
    .month_i   (a_month_i),
    .day_i     (a_day_i),
    .hour_i    (a_hour_i),
    .minute_i  (a_minute_i),
    .second_i  (a_second_i),
    .day_num_o (day_num_a),
    .valid_o   (ok_a)
  );

  cdd_date_unit u_date_b (
    .clk_i     (clk_i),
    .en_i      (unit_en),
    .year_i    (b_year_i),
    .month_i   (b_month_i),
    .day_i     (b_day_i),
    .hour_i    (b_hour_i),
    .minute_i  (b_minute_i),
    .second_i  (b_second_i),
    .day_num_o (day_num_b),
    .valid_o   (ok_b)
  );

  // Stage 1: field differences.
  logic [14:0] yd1_q;
  logic [4:0]  dmon1_q;
  logic [5:0]  dh1_q;
  logic [6:0]  dm1_q, ds1_q;

  always_ff @(posedge clk_i) begin
    if (e1) begin
      yd1_q   <= 15'(b_year_i) - 15'(a_year_i);
      dmon1_q <= 5'(b_month_i) - 5'(a_month_i);
      dh1_q   <= 6'(b_hour_i) - 6'(a_hour_i);
      dm1_q   <= 7'(b_minute_i) - 7'(a_minute_i);
      ds1_q   <= 7'(b_second_i) - 7'(a_second_i);
    end
  end

  // Stage 2: month difference.
  logic [14:0] yd2_q;
  logic [17:0] mon2_q;
  logic [5:0]  dh2_q;
  logic [6:0]  dm2_q, ds2_q;

  always_ff @(posedge clk_i) begin
    if (e2) begin
      yd2_q  <= yd1_q;
      mon2_q <= {{3{yd1_q[14]}}, yd1_q} * 18'(cdd_pkg::MONTHS_PER_YEAR)
              + {{13{dmon1_q[4]}}, dmon1_q};
      dh2_q  <= dh1_q;
      dm2_q  <= dm1_q;
      ds2_q  <= ds1_q;
    end
  end

  // Stage 3: day difference; an invalid item zeroes every gated term here,
  // so all later results come out as zero without further gating.
  logic        ok2;
  logic        ok3_q;
  logic [14:0] yd3_q;
  logic [17:0] mon3_q;
  logic [24:0] days3_q;
  logic [5:0]  dh3_q;
  logic [6:0]  dm3_q, ds3_q;

  assign ok2 = ok_a && ok_b;

  always_ff @(posedge clk_i) begin
    if (e3) begin
      ok3_q   <= ok2;
      yd3_q   <= yd2_q;
      mon3_q  <= ok2 ? mon2_q : 18'd0;
      days3_q <= ok2 ? (25'(day_num_b) - 25'(day_num_a)) : 25'd0;
      dh3_q   <= ok2 ? dh2_q : 6'd0;
      dm3_q   <= ok2 ? dm2_q : 7'd0;
      ds3_q   <= ok2 ? ds2_q : 7'd0;
    end
  end

  // Stage 4: hours, and the magnitude of the day difference for the week quotient.
  // Hours and minutes carry one bit more than their outputs, so that the later
  // products start from the exact value for years beyond the nominal range.
  logic        ok4_q;
  logic [14:0] yd4_q;
  logic [17:0] mon4_q;
  logic [22:0] days4_q;
  logic [28:0] hours4_q;
  logic [23:0] dabs4_q;
  logic        dneg4_q;
  logic [6:0]  dm4_q, ds4_q;
  logic [24:0] days3_neg;

  assign days3_neg = 25'd0 - days3_q;

  always_ff @(posedge clk_i) begin
    if (e4) begin
      ok4_q    <= ok3_q;
      yd4_q    <= yd3_q;
      mon4_q   <= mon3_q;
      days4_q  <= days3_q[22:0];
      hours4_q <= {{4{days3_q[24]}}, days3_q} * 29'(cdd_pkg::HOURS_PER_DAY)
                + {{23{dh3_q[5]}}, dh3_q};
      dneg4_q  <= days3_q[24];
      dabs4_q  <= days3_q[24] ? days3_neg[23:0] : days3_q[23:0];
      dm4_q    <= dm3_q;
      ds4_q    <= ds3_q;
    end
  end

  // Stage 5: minutes and the reciprocal product for division by seven.
  logic        ok5_q;
  logic [14:0] yd5_q;
  logic [17:0] mon5_q;
  logic [22:0] days5_q;
  logic [27:0] hours5_q;
  logic [34:0] mins5_q;
  logic [48:0] wprod5_q;
  logic        dneg5_q;
  logic [6:0]  ds5_q;

  always_ff @(posedge clk_i) begin
    if (e5) begin
      ok5_q    <= ok4_q;
      yd5_q    <= yd4_q;
      mon5_q   <= mon4_q;
      days5_q  <= days4_q;
      hours5_q <= hours4_q[27:0];
      mins5_q  <= {{6{hours4_q[28]}}, hours4_q} * 35'(cdd_pkg::MINS_PER_HOUR)
                + {{28{dm4_q[6]}}, dm4_q};
      wprod5_q <= 49'(dabs4_q) * 49'(cdd_pkg::RECIP_7);
      dneg5_q  <= dneg4_q;
      ds5_q    <= ds4_q;
    end
  end

  // Stage 6: seconds and the signed week count; this is the output register.
  logic [19:0] wq5;
  logic [19:0] wq5_neg;
  logic        ok6_q;
  logic [14:0] yd6_q;
  logic [17:0] mon6_q;
  logic [22:0] days6_q;
  logic [19:0] weeks6_q;
  logic [27:0] hours6_q;
  logic [33:0] mins6_q;
  logic [39:0] secs6_q;

  assign wq5     = wprod5_q[cdd_pkg::RECIP_7_SHIFT +: 20];
  assign wq5_neg = 20'd0 - wq5;

  always_ff @(posedge clk_i) begin
    if (e6) begin
      ok6_q    <= ok5_q;
      yd6_q    <= yd5_q;
      mon6_q   <= mon5_q;
      days6_q  <= days5_q;
      weeks6_q <= dneg5_q ? wq5_neg : wq5;
      hours6_q <= hours5_q;
      mins6_q  <= mins5_q[33:0];
      secs6_q  <= {{5{mins5_q[34]}}, mins5_q} * 40'(cdd_pkg::SECS_PER_MIN)
                + {{33{ds5_q[6]}}, ds5_q};
    end
  end

  assign both_valid_o  = ok6_q;
  assign year_diff_o   = yd6_q;
  assign month_diff_o  = mon6_q;
  assign day_diff_o    = days6_q;
  assign week_diff_o   = weeks6_q;
  assign hour_diff_o   = hours6_q;
  assign minute_diff_o = mins6_q;
  assign second_diff_o = secs6_q;

endmodule

`default_nettype wire

// ===== hdl/cdd_date_unit.sv =====
// Two-stage unit that validates one date-time and converts its date to a day number.
`default_nettype none

module cdd_date_unit (
  input  wire                     clk_i,
  input  wire cdd_pkg::stage_en_t en_i,
  input  wire [13:0]              year_i,
  input  wire [3:0]               month_i,
  input  wire [4:0]               day_i,
  input  wire [4:0]               hour_i,
  input  wire [5:0]               minute_i,
  input  wire [5:0]               second_i,
  output logic [23:0]             day_num_o,
  output logic                    valid_o
);

  // Stage 1: shifted year and the quotients by 100.
  logic [14:0] yy_d, yy_q;
  logic [27:0] prod_yy, prod_y;
  logic [7:0]  qyy_d, qyy_q;
  logic [7:0]  qy_d, qy_q;
  logic [13:0] year_q;
  logic [3:0]  month_q;
  logic [4:0]  day_q;
  logic        time_ok_d, time_ok_q;
  logic [8:0]  moff_d, moff_q;

  always_comb begin
    yy_d      = 15'(year_i) + 15'(cdd_pkg::YEAR_OFFSET)
              - ((month_i <= cdd_pkg::MONTH_FEB) ? 15'd1 : 15'd0);
    prod_yy   = 28'(yy_d) * 28'(cdd_pkg::RECIP_100);
    prod_y    = 28'(year_i) * 28'(cdd_pkg::RECIP_100);
    qyy_d     = prod_yy[cdd_pkg::RECIP_100_SHIFT +: 8];
    qy_d      = prod_y[cdd_pkg::RECIP_100_SHIFT +: 8];
    time_ok_d = (hour_i < 5'd24) && (minute_i < 6'd60) && (second_i < 6'd60);
    moff_d    = cdd_pkg::month_offset(month_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      yy_q      <= yy_d;
      qyy_q     <= qyy_d;
      qy_q      <= qy_d;
      year_q    <= year_i;
      month_q   <= month_i;
      day_q     <= day_i;
      time_ok_q <= time_ok_d;
      moff_q    <= moff_d;
    end
  end

  // Stage 2: leap rule, range checks and the day count.
  logic [13:0] rem_full;
  logic [6:0]  rem100;
  logic        leap;
  logic [4:0]  mlen;
  logic        valid_d;
  logic [23:0] day_num_d;

  always_comb begin
    rem_full  = year_q - 14'(qy_q) * 14'(cdd_pkg::CENTURY);
    rem100    = rem_full[6:0];
    leap      = ((year_q[1:0] == 2'd0) && (rem100 != 7'd0))
             || ((rem100 == 7'd0) && (qy_q[1:0] == 2'd0));
    mlen      = cdd_pkg::month_length(month_q, leap);
    valid_d   = (month_q >= cdd_pkg::MONTH_JAN) && (month_q <= cdd_pkg::MONTH_DEC)
             && (day_q != 5'd0) && (day_q <= mlen) && time_ok_q;
    day_num_d = 24'(yy_q) * 24'(cdd_pkg::DAYS_PER_YEAR) + 24'(yy_q >> 2)
              - 24'(qyy_q) + 24'(qyy_q >> 2) + 24'(moff_q) + 24'(day_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      day_num_o <= day_num_d;
      valid_o   <= valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/cdd_checker.sv =====
// Port-level checks for the date difference block and the bind that attaches them.
`default_nettype none

module cdd_checker (
  input wire               clk_i,
  input wire               rst_ni,
  input wire               in_stall_o,
  input wire               out_valid_o,
  input wire               out_stall_i,
  input wire               both_valid_o,
  input wire signed [14:0] year_diff_o,
  input wire signed [17:0] month_diff_o,
  input wire signed [22:0] day_diff_o,
  input wire signed [19:0] week_diff_o,
  input wire signed [27:0] hour_diff_o,
  input wire signed [33:0] minute_diff_o,
  input wire signed [39:0] second_diff_o
);

  // Reset empties the output register at once.
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result shown during reset");

  // The input side is held back only by a stalled, full output.
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while the output is free");

  // An invalid pair gives zero for every gated difference.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !both_valid_o |-> month_diff_o == 18'sd0 && day_diff_o == 23'sd0
      && week_diff_o == 20'sd0 && hour_diff_o == 28'sd0 && minute_diff_o == 34'sd0
      && second_diff_o == 40'sd0)
    else $error("gated difference not zero for an invalid item");

  // A stalled result stays on the port unchanged.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(both_valid_o)
      && $stable(year_diff_o) && $stable(second_diff_o) && $stable(week_diff_o))
    else $error("stalled result changed");

endmodule

bind calendar_datetime_difference cdd_checker u_cdd_checker (.*);

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the calendar date-time difference block.
`timescale 1ns / 100ps

module testbench;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } stamp_t;

  typedef struct packed {
    stamp_t a;
    stamp_t b;
  } stamp_pair_t;

  typedef struct packed {
    logic               both_valid;
    logic signed [14:0] year_diff;
    logic signed [17:0] month_diff;
    logic signed [22:0] day_diff;
    logic signed [19:0] week_diff;
    logic signed [27:0] hour_diff;
    logic signed [33:0] minute_diff;
    logic signed [39:0] second_diff;
  } diff_t;

  typedef struct {
    stamp_pair_t pair;
    bit          typed;
    diff_t       res;
  } vector_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  stamp_pair_t in_pair;
  logic        out_valid_o;
  logic        out_stall_i;
  diff_t       got;

  diff_t pending_diffs[$];
  diff_t want;
  int    mismatch_count = 0;
  int    idle_pct = 20;
  bit    hold_req = 1'b0;
  int    notable_years[16] = '{0, 1, 4, 100, 400, 1600, 1700, 1900, 2000, 2004, 2023, 2024,
                               2100, 2400, 9996, 9999};

  calendar_datetime_difference u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .a_year_i     (in_pair.a.year),
    .a_month_i    (in_pair.a.month),
    .a_day_i      (in_pair.a.day),
    .a_hour_i     (in_pair.a.hour),
    .a_minute_i   (in_pair.a.minute),
    .a_second_i   (in_pair.a.second),
    .b_year_i     (in_pair.b.year),
    .b_month_i    (in_pair.b.month),
    .b_day_i      (in_pair.b.day),
    .b_hour_i     (in_pair.b.hour),
    .b_minute_i   (in_pair.b.minute),
    .b_second_i   (in_pair.b.second),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .both_valid_o (got.both_valid),
    .year_diff_o  (got.year_diff),
    .month_diff_o (got.month_diff),
    .day_diff_o   (got.day_diff),
    .week_diff_o  (got.week_diff),
    .hour_diff_o  (got.hour_diff),
    .minute_diff_o(got.minute_diff),
    .second_diff_o(got.second_diff)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic bit is_leap(int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int month_days(int y, int m);
    case (m)
      2: return is_leap(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default: return 31;
    endcase
  endfunction

  function automatic bit stamp_ok(stamp_t s);
    if (s.month < 1 || s.month > 12) return 1'b0;
    if (s.day < 1 || s.day > month_days(s.year, s.month)) return 1'b0;
    return s.hour < 24 && s.minute < 60 && s.second < 60;
  endfunction

  // Days from a fixed epoch; the year starts in March so that the leap day falls last.
  function automatic longint day_count(stamp_t s);
    longint yy;
    longint mp;
    yy = longint'(s.year) + 400 - ((s.month <= 2) ? 1 : 0);
    mp = (longint'(s.month) + 9) % 12;
    return 365 * yy + yy / 4 - yy / 100 + yy / 400 + (153 * mp + 2) / 5 + longint'(s.day);
  endfunction

  function automatic diff_t predict_diff(stamp_pair_t p);
    diff_t  r;
    longint years;
    longint days;
    longint hours;
    longint mins;
    longint secs;
    bit     ok;
    r = '0;
    years = longint'(p.b.year) - longint'(p.a.year);
    ok = stamp_ok(p.a) && stamp_ok(p.b);
    r.both_valid = ok;
    r.year_diff = years[14:0];
    if (ok) begin
      days = day_count(p.b) - day_count(p.a);
      hours = days * 24 + (longint'(p.b.hour) - longint'(p.a.hour));
      mins = hours * 60 + (longint'(p.b.minute) - longint'(p.a.minute));
      secs = mins * 60 + (longint'(p.b.second) - longint'(p.a.second));
      r.month_diff = 18'(years * 12 + (longint'(p.b.month) - longint'(p.a.month)));
      r.day_diff = days[22:0];
      r.week_diff = 20'(days / 7);
      r.hour_diff = hours[27:0];
      r.minute_diff = mins[33:0];
      r.second_diff = secs[39:0];
    end
    return r;
  endfunction

  function automatic stamp_t mk(int y, int m, int d, int h, int mi, int s);
    stamp_t t;
    t.year = 14'(y);
    t.month = 4'(m);
    t.day = 5'(d);
    t.hour = 5'(h);
    t.minute = 6'(mi);
    t.second = 6'(s);
    return t;
  endfunction

  function automatic vector_t row(stamp_t a, stamp_t b);
    vector_t v;
    v.pair = {a, b};
    v.typed = 1'b0;
    v.res = '0;
    return v;
  endfunction

  function automatic vector_t row_exp(stamp_t a, stamp_t b, bit ok, longint yd, longint md,
                                      longint dd, longint wd, longint hd, longint nd,
                                      longint sd);
    vector_t v;
    v.pair = {a, b};
    v.typed = 1'b1;
    v.res.both_valid = ok;
    v.res.year_diff = 15'(yd);
    v.res.month_diff = 18'(md);
    v.res.day_diff = 23'(dd);
    v.res.week_diff = 20'(wd);
    v.res.hour_diff = 28'(hd);
    v.res.minute_diff = 34'(nd);
    v.res.second_diff = 40'(sd);
    return v;
  endfunction

  function automatic stamp_t rand_stamp(int yhi, int ylo);
    stamp_t s;
    s.year = 14'($urandom_range(yhi, ylo));
    s.month = 4'($urandom_range(12, 1));
    s.day = 5'($urandom_range(month_days(s.year, s.month), 1));
    s.hour = 5'($urandom_range(23, 0));
    s.minute = 6'($urandom_range(59, 0));
    s.second = 6'($urandom_range(59, 0));
    return s;
  endfunction

  // A valid stamp, often close to a month, year or day boundary.
  function automatic stamp_t boundary_stamp(int y);
    stamp_t s;
    int     m;
    int     len;
    int     k;
    k = $urandom_range(4, 0);
    m = (k == 0) ? 1 : (k == 1) ? 2 : (k == 2) ? 3 : (k == 3) ? 12 : $urandom_range(12, 1);
    len = month_days(y, m);
    k = $urandom_range(3, 0);
    s = rand_stamp(y, y);
    s.month = 4'(m);
    s.day = 5'((k == 0) ? 1 : (k == 1) ? len - 1 : (k == 2) ? len : $urandom_range(len, 1));
    k = $urandom_range(2, 0);
    if (k == 0) begin
      s.hour = 5'd0;
      s.minute = 6'd0;
      s.second = 6'd0;
    end else if (k == 1) begin
      s.hour = 5'd23;
      s.minute = 6'd59;
      s.second = 6'd59;
    end
    return s;
  endfunction

  // Breaks exactly one field of a valid stamp.
  function automatic stamp_t corrupt(stamp_t s);
    int len;
    int k;
    len = month_days(s.year, s.month);
    case ($urandom_range(4, 0))
      0: begin
        k = $urandom_range(3, 0);
        s.month = 4'((k == 0) ? 0 : 12 + k);
      end
      1: s.day = 5'((len == 31 || $urandom_range(1, 0) == 0) ? 0
                    : $urandom_range(31, len + 1));
      2: s.hour = 5'($urandom_range(31, 24));
      3: s.minute = 6'($urandom_range(63, 60));
      default: s.second = 6'($urandom_range(63, 60));
    endcase
    return s;
  endfunction

  task automatic check_field(input string name, input logic signed [63:0] exp_v,
                             input logic signed [63:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      mismatch_count++;
    end
  endtask

  task automatic offer(input stamp_pair_t p, input bit typed, input diff_t res);
    if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(14, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_pair <= p;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_diffs.push_back(typed ? res : predict_diff(p));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_diffs.size() == 0) begin
        $error("result arrived with no item outstanding");
        mismatch_count++;
      end else begin
        want = pending_diffs.pop_front();
        check_field("both_valid", want.both_valid, got.both_valid);
        check_field("year_diff", want.year_diff, got.year_diff);
        check_field("month_diff", want.month_diff, got.month_diff);
        check_field("day_diff", want.day_diff, got.day_diff);
        check_field("week_diff", want.week_diff, got.week_diff);
        check_field("hour_diff", want.hour_diff, got.hour_diff);
        check_field("minute_diff", want.minute_diff, got.minute_diff);
        check_field("second_diff", want.second_diff, got.second_diff);
      end
    end
  end

  // Output side: random stall bursts, plus one long hold-off that backs up the pipeline.
  initial begin : receiver
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (200) @(posedge clk_i);
      end else if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(14, 1)) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
    end
  end

  initial begin : stimulus
    vector_t     vectors[$];
    stamp_pair_t p;
    int          r;
    int          ny;
    int          k;

    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_pair <= '0;

    vectors.push_back(row_exp(mk(2000, 1, 1, 0, 0, 0), mk(2000, 1, 1, 0, 0, 0),
                              1, 0, 0, 0, 0, 0, 0, 0));
    vectors.push_back(row_exp(mk(1, 1, 1, 0, 0, 0), mk(9999, 12, 31, 23, 59, 59),
                              1, 9998, 119987, 3652058, 521722, 87649415,
                              64'sd5258964959, 64'sd315537897599));
    vectors.push_back(row_exp(mk(9999, 12, 31, 23, 59, 59), mk(1, 1, 1, 0, 0, 0),
                              1, -9998, -119987, -3652058, -521722, -87649415,
                              -64'sd5258964959, -64'sd315537897599));
    // Invalid on either side: only the year difference survives.
    vectors.push_back(row_exp(mk(2020, 0, 10, 8, 0, 0), mk(2021, 5, 5, 8, 0, 0),
                              0, 1, 0, 0, 0, 0, 0, 0));
    vectors.push_back(row_exp(mk(2020, 3, 10, 8, 0, 0), mk(2018, 13, 1, 8, 0, 0),
                              0, -2, 0, 0, 0, 0, 0, 0));
    vectors.push_back(row_exp(mk(3000, 15, 1, 0, 0, 0), mk(3000, 1, 1, 0, 0, 0),
                              0, 0, 0, 0, 0, 0, 0, 0));
    vectors.push_back(row_exp(mk(1999, 7, 0, 0, 0, 0), mk(2001, 7, 1, 0, 0, 0),
                              0, 2, 0, 0, 0, 0, 0, 0));
    vectors.push_back(row_exp(mk(2010, 4, 31, 0, 0, 0), mk(2010, 5, 1, 0, 0, 0),
                              0, 0, 0, 0, 0, 0, 0, 0));
    vectors.push_back(row_exp(mk(2024, 2, 30, 0, 0, 0), mk(2024, 3, 1, 0, 0, 0),
                              0, 0, 0, 0, 0, 0, 0, 0));
    // Century years are leap only when divisible by 400.
    vectors.push_back(row_exp(mk(1900, 2, 29, 0, 0, 0), mk(1901, 1, 1, 0, 0, 0),
                              0, 1, 0, 0, 0, 0, 0, 0));
    vectors.push_back(row_exp(mk(2022, 6, 1, 0, 0, 0), mk(2023, 2, 29, 0, 0, 0),
                              0, 1, 0, 0, 0, 0, 0, 0));
    vectors.push_back(row_exp(mk(2000, 1, 1, 24, 0, 0), mk(2000, 1, 2, 0, 0, 0),
                              0, 0, 0, 0, 0, 0, 0, 0));
    vectors.push_back(row_exp(mk(2000, 1, 1, 0, 0, 0), mk(2005, 1, 1, 31, 0, 0),
                              0, 5, 0, 0, 0, 0, 0, 0));
    vectors.push_back(row_exp(mk(2000, 1, 1, 0, 60, 0), mk(2000, 1, 1, 0, 0, 0),
                              0, 0, 0, 0, 0, 0, 0, 0));
    vectors.push_back(row_exp(mk(2000, 1, 1, 0, 0, 0), mk(2000, 1, 1, 0, 63, 0),
                              0, 0, 0, 0, 0, 0, 0, 0));
    vectors.push_back(row_exp(mk(2000, 1, 1, 0, 0, 60), mk(2000, 1, 1, 0, 0, 0),
                              0, 0, 0, 0, 0, 0, 0, 0));
    vectors.push_back(row_exp(mk(2000, 1, 1, 0, 0, 0), mk(2000, 1, 1, 0, 0, 63),
                              0, 0, 0, 0, 0, 0, 0, 0));
    vectors.push_back(row(mk(2000, 2, 29, 12, 0, 0), mk(2100, 3, 1, 6, 30, 15)));
    vectors.push_back(row(mk(2024, 2, 29, 23, 59, 59), mk(2024, 3, 1, 0, 0, 0)));
    vectors.push_back(row(mk(0, 2, 29, 0, 0, 0), mk(1, 1, 1, 0, 0, 0)));
    // Years beyond the nominal range wrap the wider differences.
    vectors.push_back(row(mk(0, 1, 1, 0, 0, 0), mk(16383, 12, 31, 23, 59, 59)));
    vectors.push_back(row(mk(16383, 12, 31, 23, 59, 59), mk(0, 1, 1, 0, 0, 0)));
    // Negative week counts truncate towards zero.
    vectors.push_back(row(mk(2000, 1, 10, 0, 0, 0), mk(2000, 1, 1, 0, 0, 0)));
    vectors.push_back(row(mk(2023, 12, 31, 23, 59, 59), mk(2024, 1, 1, 0, 0, 0)));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (vectors[i]) offer(vectors[i].pair, vectors[i].typed, vectors[i].res);

    for (int i = 0; i < 1750; i++) begin
      if (i % 125 == 0) begin
        k = $urandom_range(3, 0);
        idle_pct = (k == 0) ? 0 : (k == 1) ? 8 : (k == 2) ? 25 : 50;
      end
      // Keep offering items while the output is held off, so that the input backs up.
      if (i == 500) begin
        idle_pct = 0;
        hold_req = 1'b1;
      end
      if (i >= 1550) idle_pct = 0;

      r = $urandom_range(99, 0);
      if (r < 45) begin
        p.a = rand_stamp(9999, 1);
        p.b = rand_stamp(9999, 1);
      end else if (r < 70) begin
        p.a = boundary_stamp(notable_years[$urandom_range(15, 0)]);
        ny = int'(p.a.year) + int'($urandom_range(2, 0)) - 1;
        if (ny < 0) ny = 0;
        p.b = boundary_stamp(ny);
      end else if (r < 80) begin
        p.a = rand_stamp(16383, 0);
        p.b = rand_stamp(16383, 0);
      end else if (r < 95) begin
        p.a = rand_stamp(9999, 1);
        p.b = rand_stamp(9999, 1);
        k = $urandom_range(2, 0);
        if (k != 1) p.a = corrupt(p.a);
        if (k != 0) p.b = corrupt(p.b);
      end else begin
        p = 80'({$urandom, $urandom, $urandom});
      end
      offer(p, 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    while (pending_diffs.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #1000000;
    $display("status: fail");
    $finish;
  end

endmodule
